### sv/u8d_pkg.sv
// shared types and constants for the utf-8 validating decoder
package u8d_pkg;

  localparam int unsigned CpW = 21;

  // result status codes
  localparam logic [1:0] STAT_CHAR    = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_DROPPED = 2'd2;

  // lead byte class limits
  localparam logic [7:0] LEAD_ONE_MAX   = 8'h7F;
  localparam logic [7:0] CONT_MAX       = 8'hBF;
  localparam logic [7:0] LEAD_TWO_MAX   = 8'hDF;
  localparam logic [7:0] LEAD_THREE_MAX = 8'hEF;
  localparam logic [7:0] LEAD_FOUR_MAX  = 8'hF7;

  // continuation byte form 10xxxxxx
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // payload masks of the lead forms
  localparam logic [7:0] LEAD_TWO_BITS   = 8'h1F;
  localparam logic [7:0] LEAD_THREE_BITS = 8'h0F;
  localparam logic [7:0] LEAD_FOUR_BITS  = 8'h07;

  // surrogate range, rejected for four-byte forms only
  localparam logic [CpW-1:0] SURR_LO = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI = 21'h00DFFF;

  typedef struct packed {
    logic [1:0]     pending;
    logic [CpW-1:0] partial;
    logic           four_byte;
    logic           discarding;
  } u8d_state_t;

  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    logic [1:0]     status;
    logic           last;
  } u8d_result_t;

endpackage

### sv/utf8_validating_decoder.sv
// top level of the utf-8 validating decoder: byte register, decode step, result register
//
//  channel | ports    | tdata                    | tuser      | tlast
//  --------+----------+--------------------------+------------+--------------
//  input   | in_*     | [7:0] data_byte          | -          | buffer_end
//  result  | out_*    | [20:0] code_point, zeros | [1:0] stat | end_of_buffer
//
// one byte is taken every cycle while the result is not stalled; a byte passes
// the byte register, then the decode step into the result register
// bytes in the middle of a sequence or of a dropped buffer give no result
// a stalled result holds the byte register, which holds the input in turn
// reset clears the valid flags and the decoder state
module utf8_validating_decoder
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // buffer_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // end_of_buffer
);

  // byte register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // decoder state
  u8d_state_t  state_r, state_nxt;
  u8d_result_t res;

  // result register
  logic           out_valid_r, out_valid_nxt;
  logic [CpW-1:0] out_cp_r;
  logic [1:0]     out_stat_r;
  logic           out_last_r;

  logic in_fire;
  logic s1_adv;

  // the byte moves on when the result register is free or being emptied
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  u8d_step u_step (
    .cur_state  (state_r),
    .data_byte  (s1_byte_r),
    .buffer_end (s1_last_r),
    .nxt_state  (state_nxt),
    .result     (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_adv && res.valid) begin
      out_cp_r   <= res.code_point;
      out_stat_r <= res.status;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cp_r};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  // a result that is not a character carries a zero code point
  a_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_CHAR |-> out_cp_r == '0)
    else $error("non-character result with nonzero code point");

  // the end of a dropped buffer always closes the buffer
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_DROPPED |-> out_tlast)
    else $error("dropped-buffer report without end of buffer");

  // discarding never coexists with a partial sequence
  a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.discarding |-> state_r.pending == 2'd0 && state_r.partial == '0)
    else $error("partial sequence kept while discarding");

  // every buffer end leaves the decoder state cleared
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> state_r == '0)
    else $error("state not cleared at buffer end");

  // a stalled result is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_cp_r) && $stable(out_stat_r))
    else $error("stalled result changed");

endmodule

### sv/u8d_step.sv
// per-byte decode step: next state and optional result from the current state
module u8d_step
  import u8d_pkg::*;
(
  input  u8d_state_t  cur_state,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output u8d_state_t  nxt_state,
  output u8d_result_t result
);

  logic [CpW-1:0] acc;
  logic [1:0]     pend_dec;
  logic           fail;

  assign acc      = {cur_state.partial[CpW-7:0], data_byte[5:0]};
  assign pend_dec = cur_state.pending - 2'd1;

  always_comb begin
    nxt_state         = cur_state;
    result.valid      = 1'b0;
    result.code_point = '0;
    result.status     = STAT_CHAR;
    result.last       = buffer_end;
    fail              = 1'b0;

    if (cur_state.discarding) begin
      if (buffer_end) begin
        nxt_state     = '0;
        result.valid  = 1'b1;
        result.status = STAT_DROPPED;
      end
    end else if (cur_state.pending == 2'd0) begin
      if (data_byte <= LEAD_ONE_MAX) begin
        result.valid      = 1'b1;
        result.code_point = {{(CpW-8){1'b0}}, data_byte};
      end else if (data_byte <= CONT_MAX || data_byte > LEAD_FOUR_MAX) begin
        fail = 1'b1;
      end else begin
        if (data_byte <= LEAD_TWO_MAX) begin
          nxt_state.pending   = 2'd1;
          nxt_state.partial   = {{(CpW-8){1'b0}}, data_byte & LEAD_TWO_BITS};
          nxt_state.four_byte = 1'b0;
        end else if (data_byte <= LEAD_THREE_MAX) begin
          nxt_state.pending   = 2'd2;
          nxt_state.partial   = {{(CpW-8){1'b0}}, data_byte & LEAD_THREE_BITS};
          nxt_state.four_byte = 1'b0;
        end else begin
          nxt_state.pending   = 2'd3;
          nxt_state.partial   = {{(CpW-8){1'b0}}, data_byte & LEAD_FOUR_BITS};
          nxt_state.four_byte = 1'b1;
        end
        fail = buffer_end;
      end
    end else if ((data_byte & CONT_MASK) != CONT_TAG) begin
      fail = 1'b1;
    end else if (pend_dec != 2'd0) begin
      nxt_state.pending = pend_dec;
      nxt_state.partial = acc;
      fail              = buffer_end;
    end else begin
      nxt_state.pending   = 2'd0;
      nxt_state.partial   = '0;
      nxt_state.four_byte = 1'b0;
      if (cur_state.four_byte && acc >= SURR_LO && acc <= SURR_HI) begin
        fail = 1'b1;
      end else begin
        result.valid      = 1'b1;
        result.code_point = acc;
      end
    end

    // any error drops the partial sequence and reports status invalid
    if (fail) begin
      nxt_state.pending    = 2'd0;
      nxt_state.partial    = '0;
      nxt_state.four_byte  = 1'b0;
      nxt_state.discarding = ~buffer_end;
      result.valid         = 1'b1;
      result.code_point    = '0;
      result.status        = STAT_INVALID;
    end
  end

endmodule
